// ----- sv/fixed_block_pool_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator: assertion macros
// Shared concurrent assertion forms; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define FBA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle implies a result in the next
`define FBA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- sv/fba_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator: package
// Field widths, operation and status codes, register indexes.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int IDX_W   = 8;   // block index field
    localparam int LINK_W  = 9;   // link / head / count width
    localparam int WORDS_W = 7;   // block size in words
    localparam int OFS_W   = 14;  // word offset field
    localparam int CFG_W   = 9;   // widest config register

    localparam logic [LINK_W-1:0]  LINK_NULL = 9'h1FF;
    localparam logic [WORDS_W-1:0] WORDS_MIN = 7'd1;
    localparam logic [WORDS_W-1:0] WORDS_MAX = 7'd64;
    localparam logic [LINK_W-1:0]  COUNT_MIN = 9'd1;

    typedef enum logic [0:0] {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        CFG_BLOCK_COUNT = 1'b0,
        CFG_BLOCK_WORDS = 1'b1
    } cfg_idx_t;

endpackage

// ----- sv/fba_ram.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/fixed_block_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Result beats are registered, in the cycle after the request is accepted;
// one item per cycle unless out_stall holds a result. The head's link is kept
// in a register or in the link RAM's read register, so each acquire pops with
// at most one RAM read and one RAM write (the taken block's link is nulled).
// Reset (and a block_count write) rebuilds the list at once: per-entry valid
// bits are cleared and unwritten entries read as the ascending chain.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_assert.svh"

module fixed_block_pool_allocator #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_write_en,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  block_index,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  granted_index,
    output logic [13:0] granted_offset,
    output logic [8:0]  free_count,
    output logic [8:0]  min_free
);

    localparam int DEPTH = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [fba_pkg::LINK_W-1:0] CAP = fba_pkg::LINK_W'(DEPTH);

    // default link of an unwritten entry: next block, or null at the end
    function automatic logic [fba_pkg::LINK_W-1:0] dflt_link(
        input logic [fba_pkg::LINK_W-1:0] idx,
        input logic [fba_pkg::LINK_W-1:0] cnt
    );
        logic [fba_pkg::LINK_W:0] nxt;
        nxt = {1'b0, idx} + (fba_pkg::LINK_W+1)'(1);
        return (nxt < {1'b0, cnt}) ? nxt[fba_pkg::LINK_W-1:0] : fba_pkg::LINK_NULL;
    endfunction

    // config state
    logic [fba_pkg::LINK_W-1:0]  count_reg;
    logic [fba_pkg::WORDS_W-1:0] words_reg;

    // list state
    logic [fba_pkg::LINK_W-1:0] head_reg,        head_next;
    logic [fba_pkg::LINK_W-1:0] link_reg,        link_next;
    logic                       link_from_ram_reg, link_from_ram_next;
    logic [DEPTH-1:0]           valid_reg,       valid_next;
    logic [fba_pkg::LINK_W-1:0] free_blocks_reg, free_blocks_next;
    logic [fba_pkg::LINK_W-1:0] low_water_reg,   low_water_next;

    // result register
    logic                        out_valid_reg,  out_valid_next;
    fba_pkg::status_t            status_reg,     status_next;
    logic [fba_pkg::IDX_W-1:0]   gidx_reg,       gidx_next;
    logic [fba_pkg::OFS_W-1:0]   goff_reg,       goff_next;
    logic [fba_pkg::LINK_W-1:0]  free_out_reg,   free_out_next;
    logic [fba_pkg::LINK_W-1:0]  min_out_reg,    min_out_next;

    // RAM ports
    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic [fba_pkg::LINK_W-1:0] ram_wr_data;
    logic                       ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    logic [fba_pkg::LINK_W-1:0] ram_rd_data;

    logic                        in_accept;
    logic [fba_pkg::LINK_W-1:0]  cur_link;
    logic [fba_pkg::LINK_W-1:0]  idx_ext;
    logic                        acq_ok;
    logic [fba_pkg::LINK_W-1:0]  free_dec;
    logic [fba_pkg::IDX_W+fba_pkg::WORDS_W-1:0] offset_full;
    logic [fba_pkg::LINK_W-1:0]  cfg_count_eff;
    logic [fba_pkg::WORDS_W-1:0] cfg_words_eff;
    logic                        chk_empty_acq;
    logic                        chk_empty_out;

    fba_ram #(
        .WIDTH (fba_pkg::LINK_W),
        .DEPTH (DEPTH)
    ) u_links (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // handshake
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // link of the current head
    always_comb
    begin
        if (link_from_ram_reg)
        begin
            cur_link = valid_reg[head_reg[AW-1:0]] ? ram_rd_data
                                                   : dflt_link(head_reg, count_reg);
        end
        else
        begin
            cur_link = link_reg;
        end
    end

    assign idx_ext     = {1'b0, block_index};
    assign acq_ok      = (free_blocks_reg != '0) && (head_reg < count_reg);
    assign free_dec    = free_blocks_reg - fba_pkg::LINK_W'(1);
    assign offset_full = head_reg[fba_pkg::IDX_W-1:0] * words_reg;

    // config value saturation
    always_comb
    begin
        cfg_count_eff = cfg_data[fba_pkg::LINK_W-1:0];
        if (cfg_count_eff < fba_pkg::COUNT_MIN)
        begin
            cfg_count_eff = fba_pkg::COUNT_MIN;
        end
        else if (cfg_count_eff > CAP)
        begin
            cfg_count_eff = CAP;
        end
        cfg_words_eff = cfg_data[fba_pkg::WORDS_W-1:0];
        if (cfg_words_eff < fba_pkg::WORDS_MIN)
        begin
            cfg_words_eff = fba_pkg::WORDS_MIN;
        end
        else if (cfg_words_eff > fba_pkg::WORDS_MAX)
        begin
            cfg_words_eff = fba_pkg::WORDS_MAX;
        end
    end

    // acquire / release
    always_comb
    begin
        head_next          = head_reg;
        link_next          = link_reg;
        link_from_ram_next = link_from_ram_reg;
        valid_next         = valid_reg;
        free_blocks_next   = free_blocks_reg;
        low_water_next     = low_water_reg;
        ram_wr_en          = 1'b0;
        ram_wr_addr        = block_index[AW-1:0];
        ram_wr_data        = head_reg;
        ram_rd_en          = 1'b0;
        ram_rd_addr        = cur_link[AW-1:0];
        status_next        = status_reg;
        gidx_next          = gidx_reg;
        goff_next          = goff_reg;
        free_out_next      = free_out_reg;
        min_out_next       = min_out_reg;
        out_valid_next     = out_valid_reg & out_stall;

        if (in_accept)
        begin
            out_valid_next = 1'b1;
            gidx_next      = '0;
            goff_next      = '0;
            if (op == fba_pkg::OP_ACQUIRE)
            begin
                if (acq_ok)
                begin
                    // pop: head moves to its link, taken block's link goes null
                    head_next                    = cur_link;
                    ram_wr_en                    = 1'b1;
                    ram_wr_addr                  = head_reg[AW-1:0];
                    ram_wr_data                  = fba_pkg::LINK_NULL;
                    valid_next[head_reg[AW-1:0]] = 1'b1;
                    if (cur_link == head_reg)
                    begin
                        // self-linked head: its link is the null just written
                        link_next          = fba_pkg::LINK_NULL;
                        link_from_ram_next = 1'b0;
                    end
                    else
                    begin
                        // fetch the new head's link
                        link_from_ram_next = 1'b1;
                        ram_rd_en          = 1'b1;
                    end
                    free_blocks_next   = free_dec;
                    low_water_next     = (low_water_reg > free_dec) ? free_dec
                                                                    : low_water_reg;
                    status_next        = fba_pkg::ST_GRANTED;
                    gidx_next          = head_reg[fba_pkg::IDX_W-1:0];
                    goff_next          = offset_full[fba_pkg::OFS_W-1:0];
                end
                else
                begin
                    status_next = fba_pkg::ST_EMPTY;
                end
            end
            else
            begin
                if (idx_ext >= count_reg)
                begin
                    status_next = fba_pkg::ST_BAD_INDEX;
                end
                else if (free_blocks_reg >= count_reg)
                begin
                    status_next = fba_pkg::ST_FULL;
                end
                else
                begin
                    // push: released block links to the old head
                    ram_wr_en                      = 1'b1;
                    valid_next[block_index[AW-1:0]] = 1'b1;
                    head_next                      = idx_ext;
                    link_next                      = head_reg;
                    link_from_ram_next             = 1'b0;
                    free_blocks_next               = free_blocks_reg + fba_pkg::LINK_W'(1);
                    status_next                    = fba_pkg::ST_RELEASED;
                end
            end
            free_out_next = free_blocks_next;
            min_out_next  = low_water_next;
        end
    end

    // config registers and list rebuild
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= CAP;
            words_reg         <= fba_pkg::WORDS_MIN;
            head_reg          <= '0;
            link_reg          <= dflt_link('0, CAP);
            link_from_ram_reg <= 1'b0;
            valid_reg         <= '0;
            free_blocks_reg   <= CAP;
            low_water_reg     <= CAP;
        end
        else if (cfg_write_en)
        begin
            unique case (fba_pkg::cfg_idx_t'(cfg_index))
                fba_pkg::CFG_BLOCK_COUNT:
                begin
                    count_reg         <= cfg_count_eff;
                    head_reg          <= '0;
                    link_reg          <= dflt_link('0, cfg_count_eff);
                    link_from_ram_reg <= 1'b0;
                    valid_reg         <= '0;
                    free_blocks_reg   <= cfg_count_eff;
                    low_water_reg     <= cfg_count_eff;
                end
                fba_pkg::CFG_BLOCK_WORDS:
                begin
                    words_reg <= cfg_words_eff;
                end
                default:
                begin
                    words_reg <= words_reg;
                end
            endcase
        end
        else
        begin
            head_reg          <= head_next;
            link_reg          <= link_next;
            link_from_ram_reg <= link_from_ram_next;
            valid_reg         <= valid_next;
            free_blocks_reg   <= free_blocks_next;
            low_water_reg     <= low_water_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        gidx_reg     <= gidx_next;
        goff_reg     <= goff_next;
        free_out_reg <= free_out_next;
        min_out_reg  <= min_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_index  = gidx_reg;
    assign granted_offset = goff_reg;
    assign free_count     = free_out_reg;
    assign min_free       = min_out_reg;

    // checks
    assign chk_empty_acq = in_accept && !cfg_write_en && (op == fba_pkg::OP_ACQUIRE)
                           && (free_blocks_reg == '0);
    assign chk_empty_out = out_valid_reg && (status_reg == fba_pkg::ST_EMPTY)
                           && (free_blocks_reg == '0);

    `FBA_ASSERT_ALWAYS(a_free_le_count, free_blocks_reg <= count_reg, "free above pool size")
    `FBA_ASSERT_ALWAYS(a_low_le_free, low_water_reg <= free_blocks_reg, "low-water above free")
    `FBA_ASSERT_NEXT(a_empty_acquire, chk_empty_acq, chk_empty_out, "empty acquire not reported")

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator: self-checking testbench
// Drives acquire and release beats through the request channel, predicts
// each result from a local model of the free list, and compares every
// field of each result beat in order. The pool is reconfigured between
// phases, and idling is varied on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        fba_pkg::status_t st;
        logic [7:0]       idx;
        logic [13:0]      ofs;
        logic [8:0]       free_n;
        logic [8:0]       low_n;
    } pool_result_t;

    typedef struct packed {
        fba_pkg::op_t op;
        logic [7:0]   idx;
        pool_result_t res;
    } pool_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [0:0]  cfg_index = fba_pkg::CFG_BLOCK_COUNT;
    logic [8:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = 1'b0;
    logic [7:0]  block_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [7:0]  granted_index;
    logic [13:0] granted_offset;
    logic [8:0]  free_count;
    logic [8:0]  min_free;

    // free list model
    logic [8:0] free_link [0:255];
    logic [8:0] list_head;
    logic [8:0] free_total;
    logic [8:0] free_low;
    logic [8:0] reg_count;
    logic [6:0] reg_words;

    pool_req_t    pending_reqs [$];
    pool_result_t results_due [$];
    logic [7:0]   held_blocks [$];
    pool_req_t    offered;

    int beats_queued = 0;
    int beats_checked = 0;
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    fixed_block_pool_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .block_index    (block_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .granted_index  (granted_index),
        .granted_offset (granted_offset),
        .free_count     (free_count),
        .min_free       (min_free)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // effective pool size: 0 acts as 1, above 256 saturates
    function automatic int eff_pool_blocks();
        int n;
        n = reg_count;
        if (n < 1)
            n = 1;
        if (n > 256)
            n = 256;
        return n;
    endfunction

    // effective block size: 0 acts as 1, above 64 saturates
    function automatic int eff_block_words();
        int w;
        w = reg_words;
        if (w < 1)
            w = 1;
        if (w > 64)
            w = 64;
        return w;
    endfunction

    // ascending chain from block 0, counters back to full
    function automatic void rebuild_free_list();
        int n;
        n = eff_pool_blocks();
        for (int i = 0; i < 256; i++)
            free_link[i] = (i + 1 < n) ? 9'(i + 1) : fba_pkg::LINK_NULL;
        list_head = '0;
        free_total = 9'(n);
        free_low = 9'(n);
    endfunction

    // one pool operation against the model
    function automatic pool_result_t pool_apply(fba_pkg::op_t o, logic [7:0] idx);
        pool_result_t r;
        int n;
        int blk;
        logic [31:0] prod;
        n = eff_pool_blocks();
        r = '0;
        if (o == fba_pkg::OP_ACQUIRE)
        begin
            // empty, or a corrupted list whose head is no block
            if (free_total == 0 || int'(list_head) >= n)
            begin
                r.st = fba_pkg::ST_EMPTY;
            end
            else
            begin
                blk = list_head;
                list_head = free_link[blk];
                free_link[blk] = fba_pkg::LINK_NULL;
                free_total = free_total - 9'd1;
                if (free_total == 0)
                    free_low = '0;
                else if (free_low > free_total)
                    free_low = free_total;
                prod = blk * eff_block_words();
                r.st = fba_pkg::ST_GRANTED;
                r.idx = 8'(blk);
                r.ofs = prod[13:0];
            end
        end
        else
        begin
            // range first, then fullness; a free block is pushed again unchecked
            if (int'(idx) >= n)
            begin
                r.st = fba_pkg::ST_BAD_INDEX;
            end
            else if (int'(free_total) >= n)
            begin
                r.st = fba_pkg::ST_FULL;
            end
            else
            begin
                free_link[idx] = list_head;
                list_head = {1'b0, idx};
                free_total = free_total + 9'd1;
                r.st = fba_pkg::ST_RELEASED;
            end
        end
        r.free_n = free_total;
        r.low_n = free_low;
        return r;
    endfunction

    // predict, track held blocks, and queue the beat
    task automatic queue_op(fba_pkg::op_t o, logic [7:0] idx);
        pool_req_t q;
        int hit;
        q.op = o;
        q.idx = idx;
        q.res = pool_apply(o, idx);
        if (q.res.st == fba_pkg::ST_GRANTED)
            held_blocks.push_back(q.res.idx);
        if (q.res.st == fba_pkg::ST_RELEASED)
        begin
            hit = -1;
            foreach (held_blocks[k])
                if (hit < 0 && held_blocks[k] == idx)
                    hit = k;
            if (hit >= 0)
                held_blocks.delete(hit);
        end
        pending_reqs.push_back(q);
        beats_queued++;
    endtask

    // random traffic drifting between drain and refill
    task automatic queue_random(int count);
        int pick;
        int acq_pct;
        logic [7:0] idx;
        for (int i = 0; i < count; i++)
        begin
            acq_pct = ((i / 12) % 2 == 0) ? 75 : 25;
            if ($urandom_range(99) < acq_pct)
            begin
                queue_op(fba_pkg::OP_ACQUIRE, 8'($urandom));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 85 && held_blocks.size() != 0)
                    idx = held_blocks[$urandom_range(held_blocks.size() - 1)];
                else if (pick < 93)
                    idx = 8'($urandom);
                else
                    idx = 8'($urandom_range(eff_pool_blocks() - 1));
                queue_op(fba_pkg::OP_RELEASE, idx);
            end
        end
    endtask

    // register write; the model follows once the write edge has passed
    task automatic write_reg(fba_pkg::cfg_idx_t r, logic [8:0] v);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (r == fba_pkg::CFG_BLOCK_COUNT)
        begin
            reg_count = v;
            rebuild_free_list();
            held_blocks.delete();
        end
        else
        begin
            reg_words = v[6:0];
        end
    endtask

    task automatic set_idling(int s, int r);
        @(negedge clk);
        send_idle_pct = s;
        recv_idle_pct = r;
    endtask

    // every queued beat answered, plus latency margin
    task automatic wait_idle();
        while (beats_checked != beats_queued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                results_due.push_back(offered.res);
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    op <= offered.op;
                    block_index <= offered.idx;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result stall: random, or a long hold on request
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("result beat with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = results_due.pop_front();
                compare_field("status", want.st, status);
                compare_field("granted_index", want.idx, granted_index);
                compare_field("granted_offset", want.ofs, granted_offset);
                compare_field("free_count", want.free_n, free_count);
                compare_field("min_free", want.low_n, min_free);
            end
            beats_checked++;
        end
    end

    // stimulus
    initial
    begin
        logic [8:0] cnt;
        logic [8:0] wds;
        reg_count = 9'd256;
        reg_words = 7'd1;
        rebuild_free_list();
        send_idle_pct = 12;
        recv_idle_pct = 71;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset pool: grant block 0, return it, then release while full
        queue_op(fba_pkg::OP_ACQUIRE, 8'hFF);
        queue_op(fba_pkg::OP_RELEASE, 8'd0);
        queue_op(fba_pkg::OP_RELEASE, 8'd0);
        wait_idle();

        // three blocks, largest block size: double release corrupts the list
        // until an acquire finds a null head with blocks still counted free
        write_reg(fba_pkg::CFG_BLOCK_COUNT, 9'd3);
        write_reg(fba_pkg::CFG_BLOCK_WORDS, 9'd64);
        queue_op(fba_pkg::OP_ACQUIRE, 8'h00);
        queue_op(fba_pkg::OP_ACQUIRE, 8'h55);
        queue_op(fba_pkg::OP_RELEASE, 8'd0);
        queue_op(fba_pkg::OP_RELEASE, 8'd0);
        queue_op(fba_pkg::OP_ACQUIRE, 8'hAA);
        queue_op(fba_pkg::OP_ACQUIRE, 8'h00);
        queue_op(fba_pkg::OP_ACQUIRE, 8'hFF);
        queue_op(fba_pkg::OP_RELEASE, 8'd3);
        queue_op(fba_pkg::OP_RELEASE, 8'd255);
        wait_idle();

        // count zero acts as one block, words zero (upper data bits set) as one
        write_reg(fba_pkg::CFG_BLOCK_COUNT, 9'd0);
        write_reg(fba_pkg::CFG_BLOCK_WORDS, 9'h180);
        queue_op(fba_pkg::OP_ACQUIRE, 8'h00);
        queue_op(fba_pkg::OP_ACQUIRE, 8'h00);
        queue_op(fba_pkg::OP_RELEASE, 8'd1);
        queue_op(fba_pkg::OP_RELEASE, 8'd0);
        queue_op(fba_pkg::OP_RELEASE, 8'd0);
        wait_idle();

        // full 256-block pool drained to the last block, largest offset
        write_reg(fba_pkg::CFG_BLOCK_COUNT, 9'd256);
        write_reg(fba_pkg::CFG_BLOCK_WORDS, 9'd64);
        for (int i = 0; i < 257; i++)
            queue_op(fba_pkg::OP_ACQUIRE, 8'($urandom));
        queue_random(40);
        wait_idle();

        // random phases over a range of pool settings
        for (int p = 1; p <= 27; p++)
        begin
            if (p == 10)
                set_idling(71, 12);
            if (p == 19)
                set_idling(0, 0);
            case (p % 7)
                0: cnt = 9'd1;
                1: cnt = 9'($urandom_range(2, 4));
                2: cnt = 9'($urandom_range(5, 16));
                3: cnt = 9'd0;
                4: cnt = 9'($urandom_range(17, 40));
                5: cnt = 9'h1FF;
                default: cnt = 9'($urandom_range(2, 8));
            endcase
            case (p % 5)
                0: wds = 9'd0;
                1: wds = 9'd127;
                2: wds = 9'd64;
                3: wds = 9'($urandom_range(1, 127));
                default: wds = {2'($urandom), 7'($urandom)};
            endcase
            write_reg(fba_pkg::CFG_BLOCK_COUNT, cnt);
            write_reg(fba_pkg::CFG_BLOCK_WORDS, wds);
            queue_random(50);
            // long receiver hold while requests keep coming
            if (p == 4 || p == 21)
            begin
                @(negedge clk);
                hold_req = 200;
            end
            wait_idle();
        end

        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
